/* rtl/lcd_pkg.sv */
// Shared constants and types for the loop chunk dispatcher.
package lcd_pkg;

	localparam int INDEX_BITS_DEF  = 32;
	localparam int MAX_THREADS_DEF = 256;

	// Configuration register indexes.
	localparam logic [2:0] REG_LOOP_BASE    = 3'd0;
	localparam logic [2:0] REG_LOOP_END     = 3'd1;
	localparam logic [2:0] REG_STEP         = 3'd2;
	localparam logic [2:0] REG_CHUNK_SIZE   = 3'd3;
	localparam logic [2:0] REG_THREAD_COUNT = 3'd4;
	localparam logic [2:0] REG_MODE         = 3'd5;

	// Schedule modes.
	localparam logic [1:0] MODE_BLOCK   = 2'd0;
	localparam logic [1:0] MODE_CYCLIC  = 2'd1;
	localparam logic [1:0] MODE_DYNAMIC = 2'd2;
	localparam logic [1:0] MODE_GUIDED  = 2'd3;

	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	// Shared arithmetic unit operations.
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic start;
		logic op;
	} alu_req_t;

endpackage

/* rtl/lcd_ifs.sv */
// Handshake channel interfaces for requests, results and configuration.
interface lcd_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  thread_id;
	logic [31:0] round;
	modport source (output valid, action, thread_id, round, input ready);
	modport sink (input valid, action, thread_id, round, output ready);
endinterface

interface lcd_rsp_if;
	logic        valid;
	logic        ready;
	logic        granted;
	logic [31:0] first_index;
	logic [31:0] last_index;
	modport source (output valid, granted, first_index, last_index, input ready);
	modport sink (input valid, granted, first_index, last_index, output ready);
endinterface

interface lcd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/loop_chunk_dispatcher.sv */
// Top level: configuration, request sequencer and result register of the dispatcher.
// Each pass goes through the shared shift-add/restoring unit. A restart makes three passes; a
// request makes one to four, but a cyclic, dynamic or guided request with no work answers in
// the cycle after the beat. One item at a time: the next beat is taken once the result beat
// has left. arst_n clears the control and configuration state (step, chunk and threads reset
// to 1); the data registers of the arithmetic unit are not reset.
module loop_chunk_dispatcher #(
	parameter int INDEX_BITS  = lcd_pkg::INDEX_BITS_DEF,
	parameter int MAX_THREADS = lcd_pkg::MAX_THREADS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	lcd_req_if.sink   req,
	lcd_rsp_if.source rsp,
	lcd_cfg_if.sink   cfg
);

	localparam int W = INDEX_BITS;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_R1   = 4'd1;
	localparam logic [3:0] ST_R2   = 4'd2;
	localparam logic [3:0] ST_R3   = 4'd3;
	localparam logic [3:0] ST_S0A  = 4'd4;
	localparam logic [3:0] ST_S0B  = 4'd5;
	localparam logic [3:0] ST_S3A  = 4'd6;
	localparam logic [3:0] ST_SLO  = 4'd7;
	localparam logic [3:0] ST_SHI  = 4'd8;

	logic [31:0] base_q, end_q;
	logic [15:0] step_q, csz_q;
	logic [8:0]  thr_q;
	logic [1:0]  mode_q;

	logic [3:0]   st_q;
	logic [W-1:0] next_q, total_q, span_q;
	logic [7:0]   me_q;
	logic [W-1:0] x_q, y_q, k_q, last_q, lo_q;
	logic         cyc_q;
	logic         go_q, opsel_q;
	logic [W-1:0] opa_q, opb_q;
	logic         ovalid_q, ogrant_q;
	logic [31:0]  ofirst_q, olast_q;

	lcd_pkg::alu_req_t alu_req;
	logic              alu_done;
	logic [W-1:0]      p;
	logic [15:0]       r;

	logic [15:0]  s_eff, c_eff;
	logic [8:0]   t_raw, t_eff;
	logic [W-1:0] base_w, end_w, s_w, c_w, t_w;
	logic [W-1:0] k_cyc, rem_w, share, delta, n_w, lo, hc, first_w;
	logic [W:0]   sh1;
	logic         me_lt_left, take;

	assign alu_req.start = go_q;
	assign alu_req.op    = opsel_q;

	lcd_alu #(.W(W)) u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.a     (opa_q),
		.b     (opb_q),
		.done  (alu_done),
		.res   (p),
		.rem   (r)
	);

	always_comb begin
		s_eff      = (step_q == '0) ? 16'd1 : step_q;
		c_eff      = (csz_q == '0) ? 16'd1 : csz_q;
		t_raw      = (thr_q == '0) ? 9'd1 : thr_q;
		t_eff      = (int'(t_raw) > MAX_THREADS) ? 9'(MAX_THREADS) : t_raw;
		base_w     = W'(base_q);
		end_w      = W'(end_q);
		s_w        = W'(s_eff);
		c_w        = W'(c_eff);
		t_w        = W'(t_eff);
		k_cyc      = W'(req.thread_id) + W'(req.round);
		rem_w      = total_q - next_q;
		share      = p + W'(r != '0);
		sh1        = {1'b0, share} + (W + 1)'(1);
		delta      = sh1[W:1];
		me_lt_left = 16'(me_q) < r;
		n_w        = me_lt_left ? p + W'(1) : p;
		lo         = base_w + p;
		hc         = lo + span_q - s_w;
		first_w    = p + x_q;
		take       = req.valid && req.ready;
	end

	assign req.ready = (st_q == ST_IDLE) && !ovalid_q;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			end_q  <= '0;
			step_q <= 16'd1;
			csz_q  <= 16'd1;
			thr_q  <= 9'd1;
			mode_q <= lcd_pkg::MODE_BLOCK;
		end else if (cfg.valid) begin
			case (cfg.index)
				lcd_pkg::REG_LOOP_BASE:    base_q <= cfg.data;
				lcd_pkg::REG_LOOP_END:     end_q  <= cfg.data;
				lcd_pkg::REG_STEP:         step_q <= cfg.data[15:0];
				lcd_pkg::REG_CHUNK_SIZE:   csz_q  <= cfg.data[15:0];
				lcd_pkg::REG_THREAD_COUNT: thr_q  <= cfg.data[8:0];
				lcd_pkg::REG_MODE:         mode_q <= cfg.data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			next_q   <= '0;
			total_q  <= '0;
			span_q   <= '0;
			go_q     <= 1'b0;
			ovalid_q <= 1'b0;
			me_q     <= '0;
			x_q      <= '0;
			y_q      <= '0;
			k_q      <= '0;
			last_q   <= '0;
			lo_q     <= '0;
			cyc_q    <= 1'b0;
			opsel_q  <= lcd_pkg::OP_MUL;
			opa_q    <= '0;
			opb_q    <= '0;
			ogrant_q <= 1'b0;
			ofirst_q <= '0;
			olast_q  <= '0;
		end else begin
			go_q <= 1'b0;
			if (ovalid_q && rsp.ready) ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (take) begin
						me_q  <= req.thread_id;
						cyc_q <= 1'b0;
						if (req.action == lcd_pkg::ACT_RESTART) begin
							go_q <= 1'b1; opsel_q <= lcd_pkg::OP_DIV;
							opa_q <= end_w - base_w; opb_q <= s_w;
							st_q <= ST_R1;
						end else begin
							case (mode_q)
								lcd_pkg::MODE_BLOCK: begin
									go_q <= 1'b1; opsel_q <= lcd_pkg::OP_DIV;
									opa_q <= total_q; opb_q <= t_w;
									st_q <= ST_S0A;
								end
								lcd_pkg::MODE_CYCLIC: begin
									if (k_cyc >= total_q) begin
										ovalid_q <= 1'b1; ogrant_q <= 1'b0;
										ofirst_q <= '0; olast_q <= '0;
									end else begin
										k_q <= k_cyc; last_q <= k_cyc; cyc_q <= 1'b1;
										go_q <= 1'b1; opsel_q <= lcd_pkg::OP_MUL;
										opa_q <= k_cyc; opb_q <= span_q;
										st_q <= ST_SLO;
									end
								end
								lcd_pkg::MODE_DYNAMIC: begin
									if (next_q == total_q) begin
										ovalid_q <= 1'b1; ogrant_q <= 1'b0;
										ofirst_q <= '0; olast_q <= '0;
									end else begin
										k_q <= next_q; last_q <= next_q;
										next_q <= next_q + W'(1);
										go_q <= 1'b1; opsel_q <= lcd_pkg::OP_MUL;
										opa_q <= next_q; opb_q <= span_q;
										st_q <= ST_SLO;
									end
								end
								default: begin
									if (rem_w == '0) begin
										ovalid_q <= 1'b1; ogrant_q <= 1'b0;
										ofirst_q <= '0; olast_q <= '0;
									end else begin
										go_q <= 1'b1; opsel_q <= lcd_pkg::OP_DIV;
										opa_q <= rem_w; opb_q <= t_w;
										st_q <= ST_S3A;
									end
								end
							endcase
						end
					end
				end
				ST_R1: begin
					if (alu_done) begin
						go_q <= 1'b1; opsel_q <= lcd_pkg::OP_DIV;
						opa_q <= p + W'(1); opb_q <= c_w;
						st_q <= ST_R2;
					end
				end
				ST_R2: begin
					if (alu_done) begin
						total_q <= p + W'(r != '0);
						go_q <= 1'b1; opsel_q <= lcd_pkg::OP_MUL;
						opa_q <= c_w; opb_q <= s_w;
						st_q <= ST_R3;
					end
				end
				ST_R3: begin
					if (alu_done) begin
						span_q <= p;
						next_q <= '0;
						ovalid_q <= 1'b1; ogrant_q <= 1'b0;
						ofirst_q <= '0; olast_q <= '0;
						st_q <= ST_IDLE;
					end
				end
				ST_S0A: begin
					if (alu_done) begin
						if ((16'(me_q) >= 16'(t_eff)) || (n_w == '0)) begin
							ovalid_q <= 1'b1; ogrant_q <= 1'b0;
							ofirst_q <= '0; olast_q <= '0;
							st_q <= ST_IDLE;
						end else begin
							x_q <= me_lt_left ? '0 : W'(r);
							y_q <= n_w;
							go_q <= 1'b1; opsel_q <= lcd_pkg::OP_MUL;
							opa_q <= W'(me_q); opb_q <= n_w;
							st_q <= ST_S0B;
						end
					end
				end
				ST_S0B: begin
					if (alu_done) begin
						k_q <= first_w;
						last_q <= first_w + y_q - W'(1);
						go_q <= 1'b1; opsel_q <= lcd_pkg::OP_MUL;
						opa_q <= first_w; opb_q <= span_q;
						st_q <= ST_SLO;
					end
				end
				ST_S3A: begin
					if (alu_done) begin
						k_q <= next_q;
						last_q <= next_q + delta - W'(1);
						next_q <= next_q + delta;
						go_q <= 1'b1; opsel_q <= lcd_pkg::OP_MUL;
						opa_q <= next_q; opb_q <= span_q;
						st_q <= ST_SLO;
					end
				end
				ST_SLO: begin
					if (alu_done) begin
						if (cyc_q) begin
							ovalid_q <= 1'b1; ogrant_q <= 1'b1;
							ofirst_q <= 32'(lo);
							olast_q <= 32'((end_w < hc) ? end_w : hc);
							st_q <= ST_IDLE;
						end else if (last_q == total_q - W'(1)) begin
							ovalid_q <= 1'b1; ogrant_q <= 1'b1;
							ofirst_q <= 32'(lo); olast_q <= 32'(end_w);
							st_q <= ST_IDLE;
						end else if (last_q == k_q) begin
							ovalid_q <= 1'b1; ogrant_q <= 1'b1;
							ofirst_q <= 32'(lo); olast_q <= 32'(lo + span_q - W'(1));
							st_q <= ST_IDLE;
						end else begin
							// Multi-chunk range: a second product gives the end of the last chunk.
							lo_q <= lo;
							go_q <= 1'b1; opsel_q <= lcd_pkg::OP_MUL;
							opa_q <= last_q + W'(1); opb_q <= span_q;
							st_q <= ST_SHI;
						end
					end
				end
				ST_SHI: begin
					if (alu_done) begin
						ovalid_q <= 1'b1; ogrant_q <= 1'b1;
						ofirst_q <= 32'(lo_q); olast_q <= 32'(lo - W'(1));
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid       = ovalid_q;
	assign rsp.granted     = ogrant_q;
	assign rsp.first_index = ofirst_q;
	assign rsp.last_index  = olast_q;

`ifndef SYNTHESIS
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid &&
			$stable({rsp.granted, rsp.first_index, rsp.last_index}))
		else $error("result beat changed while waiting");
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !req.ready) else $error("request taken while busy");
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.granted |-> (rsp.first_index == '0) && (rsp.last_index == '0))
		else $error("refused beat carries a range");
`endif

endmodule

/* rtl/lcd_alu.sv */
// Shared iterative unit: shift-add multiply modulo 2^W or restoring divide by 16 bits.
module lcd_alu #(
	parameter int W = lcd_pkg::INDEX_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lcd_pkg::alu_req_t req,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic              done,
	output logic [W-1:0]      res,
	output logic [15:0]       rem
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic          op_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  aq_q;
	logic [W-1:0]  bq_q;
	logic [15:0]   rem_q;
	logic [15:0]   div_q;
	logic [16:0]   trial;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {rem_q, acc_q[W-1]} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q  <= req.op;
			acc_q <= (req.op == lcd_pkg::OP_DIV) ? a : '0;
			aq_q  <= a;
			bq_q  <= b;
			rem_q <= '0;
			div_q <= b[15:0];
		end else if (busy_q) begin
			if (op_q == lcd_pkg::OP_MUL) begin
				if (bq_q[0]) acc_q <= acc_q + aq_q;
				aq_q <= {aq_q[W-2:0], 1'b0};
				bq_q <= {1'b0, bq_q[W-1:1]};
			end else begin
				if (!trial[16]) begin
					rem_q <= trial[15:0];
				end else begin
					rem_q <= {rem_q[14:0], acc_q[W-1]};
				end
				acc_q <= {acc_q[W-2:0], ~trial[16]};
			end
		end
	end

	assign done = done_q;
	assign res  = acc_q;
	assign rem  = rem_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("alu started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("alu done while still busy");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(req.start)) else $error("alu busy without start");
`endif

endmodule

/* dv/loop_chunk_dispatcher_tb.sv */
// Self-checking testbench for the loop chunk dispatcher: random schedules, idling and stalls.
module loop_chunk_dispatcher_tb;

	typedef struct packed {
		logic        granted;
		logic [31:0] first_index;
		logic [31:0] last_index;
	} grant_t;

	// Tracks the dispatcher's registers and loop state and keeps the grants still owed.
	class chunk_ledger;
		bit [31:0] base, lend, span, total, next;
		bit [15:0] step, csize;
		bit [8:0]  threads;
		bit [1:0]  mode;
		grant_t    owed[$];
		int        fails;

		function new();
			base = 0; lend = 0; step = 1; csize = 1; threads = 1; mode = lcd_pkg::MODE_BLOCK;
			span = 0; total = 0; next = 0; fails = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				lcd_pkg::REG_LOOP_BASE:    base = val;
				lcd_pkg::REG_LOOP_END:     lend = val;
				lcd_pkg::REG_STEP:         step = val[15:0];
				lcd_pkg::REG_CHUNK_SIZE:   csize = val[15:0];
				lcd_pkg::REG_THREAD_COUNT: threads = val[8:0];
				lcd_pkg::REG_MODE:         mode = val[1:0];
				default: ;
			endcase
		endfunction

		function bit [31:0] lo_of(bit [31:0] k);
			bit [31:0] r;
			r = base + k * span;
			return r;
		endfunction

		function bit [31:0] hi_of(bit [31:0] k);
			bit [31:0] last, r;
			last = total - 1;
			if (k == last)
				return lend;
			r = lo_of(k) + span - 1;
			return r;
		endfunction

		function void note(logic action, logic [7:0] tid, logic [31:0] rnd);
			grant_t    g;
			bit [31:0] s, c, t, iters, diff, k, rem, share, delta, hi, first;
			bit [31:0] whole, left, n;
			g = '0;
			s = (step == 0) ? 1 : step;
			c = (csize == 0) ? 1 : csize;
			t = (threads == 0) ? 1 : threads;
			if (t > lcd_pkg::MAX_THREADS_DEF)
				t = lcd_pkg::MAX_THREADS_DEF;
			if (action == lcd_pkg::ACT_RESTART) begin
				diff = lend - base;
				iters = 1 + diff / s;
				total = iters / c + ((iters % c) != 0);
				span = c * s;
				next = 0;
			end else begin
				case (mode)
					lcd_pkg::MODE_BLOCK: begin
						whole = total / t;
						left = total % t;
						if (tid < t) begin
							if (tid < left) begin
								first = tid * (whole + 1);
								n = whole + 1;
							end else begin
								first = tid * whole + left;
								n = whole;
							end
							if (n != 0) begin
								k = first + n - 1;
								g = {1'b1, lo_of(first), hi_of(k)};
							end
						end
					end
					lcd_pkg::MODE_CYCLIC: begin
						k = tid + rnd;
						if (k < total) begin
							hi = base + (k + 1) * span - s;
							if (lend < hi)
								hi = lend;
							g = {1'b1, lo_of(k), hi};
						end
					end
					lcd_pkg::MODE_DYNAMIC: begin
						if (next != total) begin
							g = {1'b1, lo_of(next), hi_of(next)};
							next = next + 1;
						end
					end
					default: begin
						rem = total - next;
						if (rem != 0) begin
							share = rem / t + ((rem % t) != 0);
							delta = share / 2 + share[0];
							k = next + delta - 1;
							g = {1'b1, lo_of(next), hi_of(k)};
							next = next + delta;
						end
					end
				endcase
			end
			owed.push_back(g);
		endfunction

		function void check(grant_t got);
			grant_t want;
			if (owed.size() == 0) begin
				$error("unexpected result beat %p", got);
				fails++;
				return;
			end
			want = owed.pop_front();
			if (got.granted !== want.granted) begin
				$error("granted: expected %0d, got %0d", want.granted, got.granted);
				fails++;
			end
			if (got.first_index !== want.first_index) begin
				$error("first_index: expected %h, got %h", want.first_index, got.first_index);
				fails++;
			end
			if (got.last_index !== want.last_index) begin
				$error("last_index: expected %h, got %h", want.last_index, got.last_index);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	int   sent;
	chunk_ledger ledger;

	lcd_req_if req_ch();
	lcd_rsp_if rsp_ch();
	lcd_cfg_if cfg_ch();

	loop_chunk_dispatcher dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#50000000;
		$display("tb: failure");
		$finish;
	end

	// Result side stalls in bursts until the final stretch.
	initial begin
		int on_len;
		int off_len;
		@(posedge clk);
		forever begin
			on_len = $urandom_range(1, 30);
			repeat (on_len) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end
			if (!quiet) begin
				off_len = $urandom_range(1, 17);
				repeat (off_len) begin
					rsp_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			ledger.check({rsp_ch.granted, rsp_ch.first_index, rsp_ch.last_index});
	end

	// Waits until every grant has come back, then gives the block time to settle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (ledger.owed.size() != 0)
			@(posedge clk);
		repeat (160) @(posedge clk);
	endtask

	task automatic set_loop(logic [31:0] base, logic [31:0] lend, logic [15:0] step,
			logic [15:0] csize, logic [8:0] threads, logic [1:0] mode);
		logic [31:0] vals[6];
		drain();
		vals = '{base, lend, {16'd0, step}, {16'd0, csize}, {23'd0, threads}, {30'd0, mode}};
		for (int i = 0; i < 6; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= 3'(i);
			cfg_ch.data <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
			ledger.write_reg(3'(i), vals[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Leaves valid high on return so a following beat goes out back to back, unless it drops valid for a random gap.
	task automatic issue(logic action, logic [7:0] tid, logic [31:0] rnd);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.action <= action;
		req_ch.thread_id <= tid;
		req_ch.round <= rnd;
		do @(posedge clk); while (!req_ch.ready);
		ledger.note(action, tid, rnd);
		sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic ask(logic [7:0] tid, logic [31:0] rnd);
		issue(lcd_pkg::ACT_REQUEST, tid, rnd);
	endtask

	initial begin
		int reqs;
		int tmax;
		logic [31:0] base, span_len;
		logic [15:0] step, csize;
		logic [8:0]  threads;
		logic [1:0]  mode;
		logic [7:0]  tid;
		logic [31:0] rnd;
		ledger = new();
		quiet = 1'b0;
		sent = 0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= lcd_pkg::ACT_REQUEST;
		req_ch.thread_id <= '0;
		req_ch.round <= '0;
		rsp_ch.ready <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= lcd_pkg::REG_LOOP_BASE;
		cfg_ch.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before any restart the loop holds no chunks.
		ask(8'd0, 32'd0);
		issue(lcd_pkg::ACT_RESTART, 8'd0, 32'd0);
		ask(8'd0, 32'd0);
		ask(8'd255, 32'hFFFF_FFFF);
		// Full index range: iteration count wraps to zero.
		set_loop(32'd0, 32'hFFFF_FFFF, 16'd1, 16'd1, 9'd1, lcd_pkg::MODE_DYNAMIC);
		issue(lcd_pkg::ACT_RESTART, 8'hFF, 32'hFFFF_FFFF);
		ask(8'd0, 32'd0);
		// Zero step, chunk size and thread count act as one.
		set_loop(32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'd0, 16'd0, 9'd0, lcd_pkg::MODE_DYNAMIC);
		issue(lcd_pkg::ACT_RESTART, 8'd0, 32'd0);
		ask(8'd0, 32'd0);
		ask(8'd0, 32'd0);
		// Thread count above the maximum is clamped.
		set_loop(32'd100, 32'd100000, 16'd65535, 16'd65535, 9'd511, lcd_pkg::MODE_BLOCK);
		issue(lcd_pkg::ACT_RESTART, 8'd0, 32'd0);
		ask(8'd0, 32'd0);
		ask(8'd1, 32'd0);
		set_loop(32'd7, 32'd1000, 16'd3, 16'd4, 9'd256, lcd_pkg::MODE_BLOCK);
		issue(lcd_pkg::ACT_RESTART, 8'd0, 32'd0);
		ask(8'd0, 32'd0);
		ask(8'd255, 32'd0);
		set_loop(32'd7, 32'd1000, 16'd3, 16'd4, 9'd5, lcd_pkg::MODE_CYCLIC);
		issue(lcd_pkg::ACT_RESTART, 8'd0, 32'd0);
		ask(8'd2, 32'd5);
		ask(8'd255, 32'hFFFF_FF05);
		set_loop(32'd7, 32'd1000, 16'd3, 16'd4, 9'd3, lcd_pkg::MODE_GUIDED);
		issue(lcd_pkg::ACT_RESTART, 8'd0, 32'd0);
		repeat (6) ask(8'd0, 32'd0);

		while (sent < 1150) begin
			if (sent > 1000)
				quiet = 1'b1;
			mode = 2'($urandom_range(0, 3));
			if ($urandom_range(0, 9) == 0) begin
				base = $urandom();
				span_len = $urandom() % (~base + 1'b1 + (base == 0 ? 32'hFFFF_FFFF : 0));
				step = 16'($urandom());
				csize = 16'($urandom());
				threads = 9'($urandom());
			end else begin
				base = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
				span_len = $urandom_range(0, 3000);
				step = 16'($urandom_range(1, 9));
				csize = 16'($urandom_range(1, 25));
				threads = 9'($urandom_range(1, 16));
			end
			if (span_len > ~base)
				span_len = ~base;
			set_loop(base, base + span_len, step, csize, threads, mode);
			issue(lcd_pkg::ACT_RESTART, 8'($urandom()), $urandom());
			reqs = $urandom_range(8, 40);
			tmax = (threads == 0) ? 0 : ((threads > 256) ? 255 : threads - 1);
			for (int i = 0; i < reqs; i++) begin
				if ($urandom_range(0, 15) == 0) begin
					issue(lcd_pkg::ACT_RESTART, 8'($urandom()), $urandom());
				end else if ($urandom_range(0, 9) == 0) begin
					ask(8'($urandom()), $urandom());
				end else begin
					tid = 8'($urandom_range(0, tmax));
					rnd = $urandom_range(0, ledger.total + 2 > 60 ? 60 : ledger.total + 2);
					ask(tid, rnd);
				end
				if ($urandom_range(0, 60) == 0)
					drain();
			end
		end

		drain();
		if (ledger.fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
